FILE: sv/mpfa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpfa_pkg
// shared constants, types and helpers for the three-pool free-list allocator
// ----------------------------------------------------------------------------
package mpfa_pkg;

    // pool geometry
    localparam int POOL_COUNT      = 3;
    localparam int SLOTS           = 16;
    localparam int PURE_ENTRIES    = 16;
    localparam int COMMON_ENTRIES  = 16;
    localparam int DYNAMIC_ENTRIES = 16;

    localparam int LINK_DEPTH = POOL_COUNT * SLOTS;
    localparam int LINK_AW    = $clog2(LINK_DEPTH);

    // end of list marker
    localparam logic [4:0] NIL = 5'd16;

    // commands
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // pool selectors
    localparam logic [1:0] POOL_PURE    = 2'd0;
    localparam logic [1:0] POOL_COMMON  = 2'd1;
    localparam logic [1:0] POOL_DYNAMIC = 2'd2;
    // pool selector with no pool behind it
    localparam logic [1:0] POOL_BAD = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_BAD   = 2'd3;

    // link memory ports
    typedef struct packed {
        logic               en;
        logic [LINK_AW-1:0] addr;
    } link_rd_t;

    typedef struct packed {
        logic               en;
        logic [LINK_AW-1:0] addr;
        logic [4:0]         data;
    } link_wr_t;

    function automatic logic [4:0] pool_size(input logic [1:0] p);
        logic [4:0] n;
        case (p)
            POOL_PURE:   n = 5'(PURE_ENTRIES);
            POOL_COMMON: n = 5'(COMMON_ENTRIES);
            default:     n = 5'(DYNAMIC_ENTRIES);
        endcase
        return n;
    endfunction

    // link value of an entry after reset: next entry, or end of list
    function automatic logic [4:0] link_reset(input logic [LINK_AW-1:0] addr);
        logic [4:0] n;
        logic [4:0] nxt;
        n   = pool_size(addr[LINK_AW-1:4]);
        nxt = {1'b0, addr[3:0]} + 5'd1;
        return (nxt < n) ? nxt : NIL;
    endfunction

endpackage
`default_nettype wire

FILE: sv/mpfa_link_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpfa_link_mem
// link table memory, one read and one write port, registered read data;
// per-entry valid bits make unwritten entries read as their reset link
// ----------------------------------------------------------------------------
module mpfa_link_mem (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire mpfa_pkg::link_rd_t rd,
    input  wire mpfa_pkg::link_wr_t wr,
    output logic [4:0]              rd_data
);

    logic [4:0]                      mem [mpfa_pkg::LINK_DEPTH];
    logic [mpfa_pkg::LINK_DEPTH-1:0] vld_reg;
    logic [4:0]                      data_reg;
    logic [4:0]                      init_reg;
    logic                            hit_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en) begin
            data_reg <= mem[rd.addr];
            init_reg <= mpfa_pkg::link_reset(rd.addr);
            hit_reg  <= vld_reg[rd.addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr.en) begin
            vld_reg[wr.addr] <= 1'b1;
        end
    end

    assign rd_data = hit_reg ? data_reg : init_reg;

endmodule
`default_nettype wire

FILE: sv/multi_pool_free_list_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_pool_free_list_allocator
// three fixed-size block pools, each a singly linked free list
// ----------------------------------------------------------------------------
// Each command word allocates the head block of a pool or pushes a released
// block back on the front of its list, and answers with exactly one result
// word carrying status, the pool, the granted block and the free count left.
// A command is accepted in IDLE, where the link of the current head is read
// from the link memory (registered read data); in EXEC the block updates
// head, used count and link and loads the result register, then returns to
// IDLE and takes the next command. It takes no new command before the last
// is through, as an allocation must see the link memory read before
// the new head is known. A result waiting on m_tready stalls the update cycle
// only. Errors (empty pool, release into a full pool, index beyond the pool,
// unknown pool) leave all state as it was. The link table needs no clearing
// pass: valid bits make unwritten entries read as their reset link.
// ----------------------------------------------------------------------------
module multi_pool_free_list_allocator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // command channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [3:0] entry_index, [7:4] zero
    input  wire logic [2:0]  s_tuser,   // [0] cmd, [2:1] pool_select
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [3:0] granted_index, [8:4] free_count
    output logic [3:0]       m_tuser    // [1:0] status, [3:2] pool_echo
);

    typedef enum logic {IDLE, EXEC} state_t;

    state_t              state_reg;
    logic                m_valid_reg;
    logic [15:0]         m_tdata_reg;
    logic [3:0]          m_tuser_reg;

    // captured command
    logic                cmd_reg;
    logic [1:0]          pool_reg;
    logic [3:0]          idx_reg;

    // per-pool state, kept in flops (three entries)
    logic [4:0]          head_reg [mpfa_pkg::POOL_COUNT];
    logic [4:0]          used_reg [mpfa_pkg::POOL_COUNT];

    mpfa_pkg::link_rd_t  link_rd;
    mpfa_pkg::link_wr_t  link_wr;
    logic [4:0]          link_data;

    logic                s_accept;
    logic                in_cmd;
    logic [1:0]          in_pool;
    logic [3:0]          in_idx;
    logic [4:0]          in_head;

    // update cycle
    logic                go;
    logic [4:0]          cur_head;
    logic [4:0]          cur_used;
    logic [4:0]          pool_n;
    logic [1:0]          res_status;
    logic [3:0]          res_grant;
    logic [4:0]          res_free;
    logic                upd_en;
    logic [4:0]          head_next;
    logic [4:0]          used_next;

    assign in_cmd  = s_tuser[0];
    assign in_pool = s_tuser[2:1];
    assign in_idx  = s_tdata[3:0];

    assign s_tready = (state_reg == IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign in_head = (in_pool == mpfa_pkg::POOL_BAD) ? 5'd0 : head_reg[in_pool];

    // read the head's link on accept; only allocations need it
    always_comb begin
        link_rd.en   = s_accept && (in_cmd == mpfa_pkg::CMD_ALLOC)
                       && (in_pool != mpfa_pkg::POOL_BAD);
        link_rd.addr = {in_pool, in_head[3:0]};
    end

    mpfa_link_mem u_link (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd      (link_rd),
        .wr      (link_wr),
        .rd_data (link_data)
    );

    // update cycle proceeds once the result register is free
    assign go = (state_reg == EXEC) && (!m_valid_reg || m_tready);

    always_comb begin
        cur_head   = (pool_reg == mpfa_pkg::POOL_BAD) ? 5'd0 : head_reg[pool_reg];
        cur_used   = (pool_reg == mpfa_pkg::POOL_BAD) ? 5'd0 : used_reg[pool_reg];
        pool_n     = mpfa_pkg::pool_size(pool_reg);
        res_status = mpfa_pkg::STAT_OK;
        res_grant  = 4'd0;
        upd_en     = 1'b0;
        head_next  = cur_head;
        used_next  = cur_used;
        link_wr.en   = 1'b0;
        link_wr.addr = {pool_reg, idx_reg};
        link_wr.data = cur_head;

        if (pool_reg == mpfa_pkg::POOL_BAD) begin
            res_status = mpfa_pkg::STAT_BAD;
        end else if (cmd_reg == mpfa_pkg::CMD_ALLOC) begin
            if (cur_used >= pool_n || cur_head[4]) begin
                res_status = mpfa_pkg::STAT_EMPTY;
            end else begin
                // pop head
                res_grant = cur_head[3:0];
                upd_en    = 1'b1;
                head_next = link_data;
                used_next = cur_used + 5'd1;
            end
        end else begin
            if (cur_used == 5'd0) begin
                res_status = mpfa_pkg::STAT_FULL;
            end else if ({1'b0, idx_reg} >= pool_n) begin
                res_status = mpfa_pkg::STAT_BAD;
            end else begin
                // push released block on the front
                upd_en     = 1'b1;
                link_wr.en = go;
                head_next  = {1'b0, idx_reg};
                used_next  = cur_used - 5'd1;
            end
        end

        if (pool_reg == mpfa_pkg::POOL_BAD) begin
            res_free = 5'd0;
        end else begin
            res_free = (pool_n >= used_next) ? (pool_n - used_next) : 5'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            m_valid_reg <= 1'b0;
            for (int p = 0; p < mpfa_pkg::POOL_COUNT; p++) begin
                head_reg[p] <= 5'd0;
                used_reg[p] <= 5'd0;
            end
        end else begin
            // result word taken and no new one loaded this cycle
            if (m_tready && !go) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE: begin
                    if (s_accept) begin
                        cmd_reg   <= in_cmd;
                        pool_reg  <= in_pool;
                        idx_reg   <= in_idx;
                        state_reg <= EXEC;
                    end
                end
                EXEC: begin
                    if (go) begin
                        if (upd_en) begin
                            head_reg[pool_reg] <= head_next;
                            used_reg[pool_reg] <= used_next;
                        end
                        m_valid_reg <= 1'b1;
                        m_tdata_reg <= {7'd0, res_free, res_grant};
                        m_tuser_reg <= {pool_reg, res_status};
                        state_reg   <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
`default_nettype wire

FILE: sv/mpfa_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpfa_checker
// port-level checks for the allocator, bound to the top level
// ----------------------------------------------------------------------------
module mpfa_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,
    input  wire logic [3:0]  m_tuser
);

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // one command at a time
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command taken while one is in flight");

    // only a successful allocate grants a block
    a_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[1:0] != mpfa_pkg::STAT_OK) |-> m_tdata[3:0] == 4'd0)
        else $error("block granted on error");

    // unknown pool reports bad pool and no free blocks
    a_badpool: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[3:2] == mpfa_pkg::POOL_BAD)
        |-> m_tuser[1:0] == mpfa_pkg::STAT_BAD && m_tdata[8:4] == 5'd0)
        else $error("unknown pool not reported");

    // free count never beyond a pool's size
    a_free: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[8:4] <= 5'(mpfa_pkg::SLOTS))
        else $error("free count out of range");

endmodule

bind multi_pool_free_list_allocator mpfa_checker u_mpfa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
